/* hdl/assert_macros.svh */
// Assertion macros, included by the move-to-front list top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// The consequent must hold at the edge where the antecedent holds.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold at the edge after the antecedent holds.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/mtfrl_pkg.sv */
`timescale 1ns / 1ps
package mtfrl_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int VALUE_W    = $clog2(LIST_DEPTH + 1);
    localparam int POS_W      = $clog2(LIST_DEPTH);
    localparam int CMD_W      = 2;

    localparam logic [CMD_W-1:0] CMD_ACCESS  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    typedef struct packed {
        logic               valid;
        logic               is_read;
        logic [VALUE_W-1:0] carry;
        logic [VALUE_W-1:0] key;
        logic [POS_W-1:0]   count;
    } t_token;

endpackage

/* hdl/mtfrl_cell.sv */
`timescale 1ns / 1ps
module mtfrl_cell
    import mtfrl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [VALUE_W-1:0] i_init_value,
    input  logic               i_restore,
    input  t_token             i_token,
    output t_token             o_token,
    output logic               o_done,
    output logic [VALUE_W-1:0] o_read_value
);

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;
    t_token             r_token;
    t_token             n_token;

    always_comb begin
        n_value      = r_value;
        n_token      = i_token;
        n_token.valid = 1'b0;
        o_done       = 1'b0;
        o_read_value = '0;
        if (i_restore) begin
            n_value = i_init_value;
        end else if (i_token.valid) begin
            if (!i_token.is_read) begin
                // The incoming value takes this place; the old one moves on
                // unless it is the value being brought to the front.
                n_value = i_token.carry;
                if (r_value == i_token.key) begin
                    o_done = 1'b1;
                end else begin
                    n_token.valid = 1'b1;
                    n_token.carry = r_value;
                end
            end else if (i_token.count == '0) begin
                o_done       = 1'b1;
                o_read_value = r_value;
            end else begin
                n_token.valid = 1'b1;
                n_token.count = i_token.count - POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value       <= i_init_value;
            r_token.valid <= 1'b0;
        end else begin
            r_value <= n_value;
            r_token <= n_token;
        end
    end

    assign o_token = r_token;

endmodule

/* hdl/move_to_front_recency_list.sv */
`timescale 1ns / 1ps
// Move-to-front list of the values 1..n held in a row of cells. An access
// request travels down the row one cell per clock, each cell taking the value
// of its neighbor, and stops at the cell that held the accessed value; a read
// request counts down the row to the requested place. An access to the value
// at place k, or a read of place k, keeps busy high until it reaches the
// cell at place k, and no new request is taken while busy is high. Restart,
// an unused command and a rejected request finish without raising busy. The
// result appears on the strobe in the cycle after the request finishes and
// cannot be held off. Writing the list size also restores ascending order.
`include "assert_macros.svh"
module move_to_front_recency_list
    import mtfrl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [VALUE_W-1:0] i_item_value,
    input  logic [POS_W-1:0]   i_position,
    output logic               o_strobe,
    output logic [VALUE_W-1:0] o_read_value,
    output logic               o_error,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [VALUE_W-1:0] i_cfg_data
);

    logic               r_busy;
    logic               r_strobe;
    logic [VALUE_W-1:0] r_read_value;
    logic               r_error;
    logic [VALUE_W-1:0] r_list_size;

    logic               w_accept;
    logic               w_cfg_write;
    logic               w_restore;
    logic [VALUE_W-1:0] w_size;
    logic               w_access_bad;
    logic               w_read_bad;
    logic               w_inject;
    logic               w_quick;
    logic               w_quick_error;
    t_token             w_token_in;
    t_token             w_token_out [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] w_done;
    logic [LIST_DEPTH-1:0] w_pass;
    logic [VALUE_W-1:0] w_cell_read [LIST_DEPTH];
    logic [VALUE_W-1:0] w_read_any;
    logic               w_any_done;

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;
    assign w_accept    = start && !r_busy;
    assign w_cfg_write = i_cfg_valid && !r_busy;

    always_comb begin
        if (r_list_size == '0) begin
            w_size = VALUE_W'(1);
        end else if (r_list_size > VALUE_W'(LIST_DEPTH)) begin
            w_size = VALUE_W'(LIST_DEPTH);
        end else begin
            w_size = r_list_size;
        end
    end

    assign w_access_bad = (i_item_value == '0) || (i_item_value > w_size);
    assign w_read_bad   = ({1'b0, i_position} >= w_size);

    always_comb begin
        w_inject      = 1'b0;
        w_quick       = 1'b0;
        w_quick_error = 1'b0;
        w_restore     = w_cfg_write;
        if (w_accept) begin
            unique case (i_cmd)
                CMD_ACCESS: begin
                    w_inject      = !w_access_bad;
                    w_quick       = w_access_bad;
                    w_quick_error = w_access_bad;
                end
                CMD_READ: begin
                    w_inject      = !w_read_bad;
                    w_quick       = w_read_bad;
                    w_quick_error = w_read_bad;
                end
                CMD_RESTART: begin
                    w_quick   = 1'b1;
                    w_restore = 1'b1;
                end
                default: begin
                    w_quick = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        w_token_in.valid   = w_inject;
        w_token_in.is_read = (i_cmd == CMD_READ);
        w_token_in.carry   = i_item_value;
        w_token_in.key     = i_item_value;
        w_token_in.count   = i_position;
    end

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        t_token w_cell_in;
        if (g == 0) begin : g_head
            assign w_cell_in = w_token_in;
        end else begin : g_body
            assign w_cell_in = w_token_out[g-1];
        end
        mtfrl_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_init_value (VALUE_W'(g + 1)),
            .i_restore    (w_restore),
            .i_token      (w_cell_in),
            .o_token      (w_token_out[g]),
            .o_done       (w_done[g]),
            .o_read_value (w_cell_read[g])
        );
        assign w_pass[g] = w_token_out[g].valid;
    end

    always_comb begin
        w_read_any = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            w_read_any = w_read_any | w_cell_read[i];
        end
    end

    assign w_any_done = |w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_strobe    <= 1'b0;
            r_list_size <= VALUE_W'(LIST_DEPTH);
        end else begin
            r_strobe <= w_any_done || w_quick;
            if (w_any_done) begin
                r_busy <= 1'b0;
            end else if (w_inject) begin
                r_busy <= 1'b1;
            end
            if (w_cfg_write) begin
                r_list_size <= i_cfg_data;
            end
        end
        r_read_value <= w_any_done ? w_read_any : '0;
        r_error      <= w_any_done ? 1'b0 : w_quick_error;
    end

    assign o_strobe     = r_strobe;
    assign o_read_value = r_read_value;
    assign o_error      = r_error;

    `ASSERT_ALWAYS(a_one_cell_done, i_clk, i_rst_n, $onehot0(w_done))
    `ASSERT_ALWAYS(a_tail_never_passes, i_clk, i_rst_n, !w_token_out[LIST_DEPTH-1].valid)
    `ASSERT_IMPLIES(a_busy_one_token, i_clk, i_rst_n, r_busy, $onehot(w_pass))
    `ASSERT_IMPLIES(a_idle_no_token, i_clk, i_rst_n, !r_busy, w_pass == '0)
    `ASSERT_NEXT(a_accept_tracked, i_clk, i_rst_n, w_accept, r_strobe || r_busy)

endmodule
